// ----- sv/tle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types, key codes, result codes and the command word table for the
// terminal line editor.
// ----------------------------------------------------------------------------
package tle_pkg;

   // Line geometry
   localparam int LINE_CAPACITY = 32;
   localparam int CAP_W         = $clog2(LINE_CAPACITY + 1); // cursor, length
   localparam int IDX_W         = $clog2(LINE_CAPACITY);     // store address
   localparam int MATCH_LEN     = 6;                         // longest word
   localparam int NUM_WORDS     = 5;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int ECHO_W   = 7;
   localparam int STATUS_W = 2;
   localparam int CMD_W    = 3;

   // Received key codes
   localparam logic [BYTE_W-1:0] KEY_EOT       = 8'd4;
   localparam logic [BYTE_W-1:0] KEY_BACKSPACE = 8'd8;
   localparam logic [BYTE_W-1:0] KEY_ENTER     = 8'd13;
   localparam logic [BYTE_W-1:0] KEY_RIGHT     = 8'd14;
   localparam logic [BYTE_W-1:0] KEY_LEFT      = 8'd15;
   localparam logic [BYTE_W-1:0] KEY_EM        = 8'd25;
   localparam logic [BYTE_W-1:0] KEY_SPACE     = 8'd32;
   localparam logic [BYTE_W-1:0] KEY_DEL       = 8'd127;

   localparam logic [ECHO_W-1:0] ECHO_BELL = 7'd7;
   localparam logic [ECHO_W-1:0] ECHO_NONE = 7'd0;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_CONTINUE = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_END      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DISCARD  = 2'd2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INVALID = 3'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_EXIT    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TRAIN   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

   // First MATCH_LEN bytes of the line, byte 0 leftmost
   typedef logic [0:MATCH_LEN-1][BYTE_W-1:0] head_type;

   // Words zero padded; store bytes past the line end are always zero
   localparam head_type WORD_TEXT [NUM_WORDS] = '{
      {"clear", 8'h00},
      {"exit",  16'h0000},
      "train!",
      {"write", 8'h00},
      {"read",  16'h0000}
   };
   localparam logic [CAP_W-1:0] WORD_LEN [NUM_WORDS] = '{
      CAP_W'(5), CAP_W'(4), CAP_W'(6), CAP_W'(5), CAP_W'(4)
   };
   localparam logic [CMD_W-1:0] WORD_CMD [NUM_WORDS] = '{
      CMD_CLEAR, CMD_EXIT, CMD_TRAIN, CMD_WRITE, CMD_READ
   };

   // Line state update for one keystroke
   typedef struct packed {
      logic                  store_we;
      logic [IDX_W-1:0]      store_addr;
      logic [BYTE_W-1:0]     store_data;
      logic                  clear_line;
      logic [CAP_W-1:0]      cursor_next;
      logic [CAP_W-1:0]      length_next;
   } edit_type;

   // One result item
   typedef struct packed {
      logic                  echo_present;
      logic [ECHO_W-1:0]     echo_byte;
      logic [STATUS_W-1:0]   status_code;
      logic                  command_ready;
      logic [CMD_W-1:0]      command_code;
   } result_type;

endpackage

// ----- sv/terminal_line_editor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_top
// Terminal line editor with command match: one received byte in, one
// echo / status / command result out.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock while the result side does not
// stall and gives one result transfer per input transfer, in order. A byte
// is held in the input register, decoded and applied to the line by
// combinational logic, and its result is loaded into the result register
// that drives rsp_*; with no stall the block sustains one byte per cycle.
// That rate is set by the combinational edit path (decode, cursor/length
// update, and the parallel compare of the first six line bytes against the
// five command words). The line store is 32 bytes of flip-flops, cleared
// all at once by reset, enter or EM, so the block needs no startup sweep and
// is ready right after reset. req_stall rises only when both the input and
// result registers are full and the result side is stalling.
// ----------------------------------------------------------------------------
module terminal_line_editor_top import tle_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // byte channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_in_byte,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_echo_present,
   output logic [ECHO_W-1:0]    rsp_echo_byte,
   output logic [STATUS_W-1:0]  rsp_status_code,
   output logic                 rsp_command_ready,
   output logic [CMD_W-1:0]     rsp_command_code
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   result_type        result_ff;

   // handshake
   logic              out_free;   // result register can load this cycle
   logic              advance;    // byte moves from input to result register
   logic              req_take;

   // line state and decode
   logic [CAP_W-1:0]  cursor;
   logic [CAP_W-1:0]  length;
   head_type          line_head;
   logic [CMD_W-1:0]  match_code;
   edit_type          edit;
   result_type        result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // input register refills whenever it is empty or draining this cycle
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   // line store, cursor and length; updated as each byte advances, so the
   // next byte always decodes against the line its predecessor left
   tle_line_state u_line_state (
      .clock     (clock),
      .reset     (reset),
      .update    (advance),
      .edit      (edit),
      .cursor    (cursor),
      .length    (length),
      .line_head (line_head)
   );

   // command word compare, only used on enter
   tle_match u_match (
      .line_head    (line_head),
      .line_length  (length),
      .command_code (match_code)
   );

   tle_edit u_edit (
      .in_byte    (in_byte_ff),
      .cursor     (cursor),
      .length     (length),
      .match_code (match_code),
      .edit       (edit),
      .result     (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_echo_present  = result_ff.echo_present;
   assign rsp_echo_byte     = result_ff.echo_byte;
   assign rsp_status_code   = result_ff.status_code;
   assign rsp_command_ready = result_ff.command_ready;
   assign rsp_command_code  = result_ff.command_code;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------

   // cursor never runs past the line end
   assert property (@(posedge clock) disable iff (reset)
      cursor <= length)
      else $error("cursor beyond line length");

   // back pressure only when a stalled result is holding the output register
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (out_valid_ff && rsp_stall && in_valid_ff))
      else $error("input stalled without a stalled result");

   // enter or EM leaves an empty line with the cursor home
   assert property (@(posedge clock) disable iff (reset)
      (advance && (in_byte_ff == KEY_ENTER || in_byte_ff == KEY_EM))
         |=> (length == '0 && cursor == '0))
      else $error("line not cleared after enter or EM");

   // a completed command never carries an echo
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.command_ready) |-> !result_ff.echo_present)
      else $error("command result with echo");

endmodule

// ----- sv/tle_match.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_match
// Compares the current line with the fixed command words; first hit wins.
// ----------------------------------------------------------------------------
module tle_match import tle_pkg::*; (
   input  head_type           line_head,
   input  logic [CAP_W-1:0]   line_length,
   output logic [CMD_W-1:0]   command_code
);

   logic [NUM_WORDS-1:0] hit;

   always_comb begin
      for (int w = 0; w < NUM_WORDS; w++) begin
         hit[w] = (line_length == WORD_LEN[w]) && (line_head == WORD_TEXT[w]);
      end
   end

   always_comb begin
      command_code = CMD_INVALID;
      // walk down so the lowest matching word is left standing
      for (int w = NUM_WORDS - 1; w >= 0; w--) begin
         if (hit[w]) begin
            command_code = WORD_CMD[w];
         end
      end
   end

endmodule

// ----- sv/tle_edit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_edit
// Decodes one received byte against cursor and length: builds the result
// item and the line state update.
// ----------------------------------------------------------------------------
module tle_edit import tle_pkg::*; (
   input  logic [BYTE_W-1:0]  in_byte,
   input  logic [CAP_W-1:0]   cursor,
   input  logic [CAP_W-1:0]   length,
   input  logic [CMD_W-1:0]   match_code,
   output edit_type           edit,
   output result_type         result
);

   logic [CAP_W-1:0] cursor_dec;
   logic [CAP_W-1:0] cursor_inc;
   logic [CAP_W-1:0] length_dec;
   logic             at_start;
   logic             at_end;

   assign cursor_dec = cursor - 1'b1;
   assign cursor_inc = cursor + 1'b1;
   assign length_dec = length - 1'b1;
   assign at_start   = (cursor == '0);
   assign at_end     = (cursor == length);

   always_comb begin
      result             = '0;
      result.echo_byte   = ECHO_NONE;
      result.status_code = STATUS_CONTINUE;
      result.command_code = CMD_INVALID;
      edit.store_we      = 1'b0;
      edit.store_addr    = cursor[IDX_W-1:0];
      edit.store_data    = '0;
      edit.clear_line    = 1'b0;
      edit.cursor_next   = cursor;
      edit.length_next   = length;

      priority if (in_byte == KEY_ENTER) begin
         result.command_ready = 1'b1;
         result.command_code  = match_code;
         edit.clear_line      = 1'b1;
         edit.cursor_next     = '0;
         edit.length_next     = '0;
      end else if (in_byte == KEY_BACKSPACE) begin
         result.echo_present = 1'b1;
         if (at_start) begin
            result.echo_byte = ECHO_BELL;
         end else begin
            result.echo_byte = in_byte[ECHO_W-1:0];
            edit.cursor_next = cursor_dec;
            edit.store_we    = 1'b1;
            edit.store_addr  = cursor_dec[IDX_W-1:0];
            if (at_end) begin
               edit.length_next = length_dec;
            end else begin
               edit.store_data = KEY_SPACE;
            end
         end
      end else if (in_byte == KEY_RIGHT) begin
         result.echo_present = 1'b1;
         if (cursor < length) begin
            edit.cursor_next = cursor_inc;
            result.echo_byte = in_byte[ECHO_W-1:0];
         end else begin
            result.echo_byte = ECHO_BELL;
         end
      end else if (in_byte == KEY_LEFT) begin
         result.echo_present = 1'b1;
         if (!at_start) begin
            edit.cursor_next = cursor_dec;
            result.echo_byte = in_byte[ECHO_W-1:0];
         end else begin
            result.echo_byte = ECHO_BELL;
         end
      end else if (in_byte == KEY_EOT) begin
         result.status_code = STATUS_END;
      end else if (in_byte == KEY_EM) begin
         result.status_code = STATUS_DISCARD;
         edit.clear_line    = 1'b1;
         edit.cursor_next   = '0;
         edit.length_next   = '0;
      end else if (in_byte < KEY_SPACE) begin
         // other control bytes: no echo, no change
      end else if (in_byte == KEY_DEL) begin
         result.echo_present = 1'b1;
         if (length == '0 || at_end) begin
            result.echo_byte = ECHO_BELL;
         end else begin
            result.echo_byte = in_byte[ECHO_W-1:0];
            edit.store_we    = 1'b1;
            if (cursor == length_dec) begin
               edit.length_next = length_dec;
            end else begin
               edit.store_data = KEY_SPACE;
            end
         end
      end else if (in_byte < KEY_DEL) begin
         result.echo_present = 1'b1;
         if (cursor < CAP_W'(LINE_CAPACITY)) begin
            result.echo_byte = in_byte[ECHO_W-1:0];
            edit.store_we    = 1'b1;
            edit.store_data  = in_byte;
            edit.cursor_next = cursor_inc;
            if (at_end) begin
               edit.length_next = cursor_inc;
            end
         end else begin
            result.echo_byte = ECHO_BELL;
         end
      end else begin
         // high bytes
         result.echo_present = 1'b1;
         result.echo_byte    = ECHO_BELL;
      end
   end

endmodule

// ----- sv/tle_line_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_line_state
// Line store, cursor and length registers; applies one edit per update.
// ----------------------------------------------------------------------------
module tle_line_state import tle_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               update,
   input  edit_type           edit,
   output logic [CAP_W-1:0]   cursor,
   output logic [CAP_W-1:0]   length,
   output head_type           line_head
);

   logic [BYTE_W-1:0] store_ff [LINE_CAPACITY];
   logic [CAP_W-1:0]  cursor_ff;
   logic [CAP_W-1:0]  length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LINE_CAPACITY; i++) begin
            store_ff[i] <= '0;
         end
      end else if (update) begin
         if (edit.clear_line) begin
            for (int i = 0; i < LINE_CAPACITY; i++) begin
               store_ff[i] <= '0;
            end
         end else if (edit.store_we) begin
            store_ff[edit.store_addr] <= edit.store_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
         length_ff <= '0;
      end else if (update) begin
         cursor_ff <= edit.cursor_next;
         length_ff <= edit.length_next;
      end
   end

   always_comb begin
      for (int i = 0; i < MATCH_LEN; i++) begin
         line_head[i] = store_ff[i];
      end
   end

   assign cursor = cursor_ff;
   assign length = length_ff;

endmodule
